// File: hdl/mav2fb_pkg.sv
// Shared types and constants for the MAVLink v2 frame builder.
package mav2fb_pkg;

  localparam int MAX_PAYLOAD_DEF = 255;
  localparam logic [7:0] START_MARKER_RST = 8'd253;

  // Two message slots: one being loaded, one being sent.
  localparam int SLOT_W = 1;
  localparam int QDEPTH = 1 << SLOT_W;

  // Frame byte index: up to 10 header + 255 payload + 2 crc bytes.
  localparam int FIDX_W = 9;
  localparam int HDR_LEN = 10;

  typedef struct packed {
    logic [7:0]  seq_number;
    logic [7:0]  system_id;
    logic [7:0]  component_id;
    logic [23:0] message_id;
    logic [7:0]  schema_byte;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        payload_last;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [3:0]  byte_count;
    logic        frame_last;
    logic        too_long;
  } out_beat_t;

  // One finished message handed from the front to the back.
  typedef struct packed {
    logic        too_long;
    logic [7:0]  len;
    logic [47:0] hdr;
    logic [7:0]  extra;
  } job_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
  } q_status_t;

endpackage

// File: hdl/mavlink2_frame_builder.sv
// Top level of the MAVLink v2 frame builder: front, message queue, payload RAM, back.
//
//  channel   dir  handshake              beat contents
//  in        in   in_valid / in_stall    in_beat_t: header fields, one payload byte, last flag
//  out       out  out_valid / out_stall  out_beat_t: up to 8 frame bytes, count, last, too_long
//  cfg       in   cfg_wr_en              cfg_wr_data: start marker byte
//
// Input takes one beat per cycle while a message slot is free; there are two slots.
// A frame is 12+n bytes: the back walks it one byte per cycle, while the output is not
// stalled, through the CRC and word packer.
// Reset is synchronous; start marker resets to 253. Payload RAM is not cleared.
// in_stall is high while both slots hold messages the back has not finished walking.
module mavlink2_frame_builder #(
  parameter int MAX_PAYLOAD = mav2fb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mav2fb_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mav2fb_pkg::out_beat_t out_data,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data
);

  localparam int IDX_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int RAM_DEPTH = mav2fb_pkg::QDEPTH << IDX_W;
  localparam int AW        = mav2fb_pkg::SLOT_W + IDX_W;

  logic [7:0]            start_marker_r;
  mav2fb_pkg::q_status_t q_stat;
  mav2fb_pkg::job_t      push_job, head;
  logic                  push, pop;
  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
  logic [7:0]            ram_wr_data, ram_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= mav2fb_pkg::START_MARKER_RST;
    end else if (cfg_wr_en) begin
      start_marker_r <= cfg_wr_data;
    end
  end

  mav2fb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  mav2fb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mav2fb_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  mav2fb_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_marker (start_marker_r),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

// File: hdl/mav2fb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mav2fb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/mav2fb_front.sv
// Front end: accepts input beats, loads payload bytes, captures header, queues messages.
module mav2fb_front #(
  parameter int MAX_PAYLOAD = mav2fb_pkg::MAX_PAYLOAD_DEF,
  parameter int IDX_W = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  mav2fb_pkg::in_beat_t                  in_data,
  input  mav2fb_pkg::q_status_t                 q_stat,
  output logic                                  push,
  output mav2fb_pkg::job_t                      push_job,
  output logic                                  ram_wr_en,
  output logic [mav2fb_pkg::SLOT_W+IDX_W-1:0]   ram_wr_addr,
  output logic [7:0]                            ram_wr_data
);

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] nz_r, nz_nxt;
  logic             ovf_r, ovf_nxt;
  logic [47:0]      hdr_r, hdr_nxt;
  logic [7:0]       extra_r, extra_nxt;
  logic             accept;
  logic             first;
  logic             store;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign first    = (cnt_r == '0) && !ovf_r;
  assign store    = accept && in_data.has_byte && !ovf_r && (cnt_r != IDX_W'(MAX_PAYLOAD));

  assign ram_wr_en   = store;
  assign ram_wr_addr = {q_stat.wr_slot, cnt_r};
  assign ram_wr_data = in_data.payload_byte;

  always_comb begin
    cnt_nxt   = cnt_r;
    nz_nxt    = nz_r;
    ovf_nxt   = ovf_r;
    hdr_nxt   = hdr_r;
    extra_nxt = extra_r;
    push      = 1'b0;
    if (accept) begin
      if (first) begin
        hdr_nxt   = {in_data.message_id, in_data.component_id,
                     in_data.system_id, in_data.seq_number};
        extra_nxt = in_data.schema_byte;
      end
      if (in_data.has_byte) begin
        if (store) begin
          cnt_nxt = cnt_r + IDX_W'(1);
          if (in_data.payload_byte != 8'h00) begin
            nz_nxt = cnt_r + IDX_W'(1);
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
    push_job.too_long = ovf_nxt;
    push_job.len      = 8'(nz_nxt);
    push_job.hdr      = hdr_nxt;
    push_job.extra    = extra_nxt;
    if (accept && in_data.payload_last) begin
      push    = 1'b1;
      cnt_nxt = '0;
      nz_nxt  = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      nz_r    <= '0;
      ovf_r   <= 1'b0;
      hdr_r   <= '0;
      extra_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      nz_r    <= nz_nxt;
      ovf_r   <= ovf_nxt;
      hdr_r   <= hdr_nxt;
      extra_r <= extra_nxt;
    end
  end

endmodule

// File: hdl/mav2fb_queue.sv
// Two-entry message queue between front and back; entry slot doubles as RAM bank.
module mav2fb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mav2fb_pkg::job_t      push_job,
  input  logic                  pop,
  output mav2fb_pkg::job_t      head,
  output mav2fb_pkg::q_status_t q_stat
);

  mav2fb_pkg::job_t               ent_r [mav2fb_pkg::QDEPTH];
  logic [mav2fb_pkg::SLOT_W-1:0]  wp_r, rp_r;
  logic [mav2fb_pkg::SLOT_W:0]    cnt_r, cnt_nxt;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + (mav2fb_pkg::SLOT_W + 1)'(1);
      2'b01:   cnt_nxt = cnt_r - (mav2fb_pkg::SLOT_W + 1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + mav2fb_pkg::SLOT_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + mav2fb_pkg::SLOT_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head           = ent_r[rp_r];
  assign q_stat.empty   = (cnt_r == '0);
  assign q_stat.full    = (cnt_r == (mav2fb_pkg::SLOT_W + 1)'(mav2fb_pkg::QDEPTH));
  assign q_stat.wr_slot = wp_r;
  assign q_stat.rd_slot = rp_r;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != (mav2fb_pkg::SLOT_W + 1)'(mav2fb_pkg::QDEPTH)))
    else $error("push into full message queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("pop from empty message queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (mav2fb_pkg::SLOT_W + 1)'(mav2fb_pkg::QDEPTH))
    else $error("message queue count out of range");

endmodule

// File: hdl/mav2fb_back.sv
// Back end: walks frames 1 byte/cycle unless stalled; runs CRC, packs 8-byte words.
module mav2fb_back #(
  parameter int IDX_W = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [7:0]                          start_marker,
  input  mav2fb_pkg::job_t                    head,
  input  mav2fb_pkg::q_status_t               q_stat,
  output logic                                pop,
  output logic [mav2fb_pkg::SLOT_W+IDX_W-1:0] ram_rd_addr,
  input  logic [7:0]                          ram_rd_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mav2fb_pkg::out_beat_t               out_data
);

  localparam int PW = mav2fb_pkg::FIDX_W;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ (t << 4);
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

  logic                  state_r, state_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic [2:0]            wc_r, wc_nxt;
  logic [63:0]           asm_r, asm_nxt;
  logic                  out_valid_r, out_valid_nxt;
  mav2fb_pkg::out_beat_t out_data_r, out_data_nxt;

  logic          out_free;
  logic [PW-1:0] crc_p, pay_end, last_p, rd_full;
  logic [7:0]    b, hb;
  logic [15:0]   crc1, crc_upd;
  logic          is_final, completes, advance, crc_hit;
  logic [63:0]   word_b;

  assign out_free = !out_valid_r || !out_stall;
  assign crc_p    = PW'(head.len) + PW'(mav2fb_pkg::HDR_LEN - 1);
  assign pay_end  = PW'(head.len) + PW'(mav2fb_pkg::HDR_LEN);
  assign last_p   = PW'(head.len) + PW'(mav2fb_pkg::HDR_LEN + 1);

  always_comb begin
    unique case (p_r[3:0])
      4'd4:    hb = head.hdr[7:0];
      4'd5:    hb = head.hdr[15:8];
      4'd6:    hb = head.hdr[23:16];
      4'd7:    hb = head.hdr[31:24];
      4'd8:    hb = head.hdr[39:32];
      4'd9:    hb = head.hdr[47:40];
      default: hb = 8'h00;
    endcase
  end

  always_comb begin
    priority if (p_r == PW'(0)) begin
      b = start_marker;
    end else if (p_r == PW'(1)) begin
      b = head.len;
    end else if (p_r < PW'(4)) begin
      b = 8'h00;
    end else if (p_r < PW'(mav2fb_pkg::HDR_LEN)) begin
      b = hb;
    end else if (p_r < pay_end) begin
      b = ram_rd_data;
    end else if (p_r == pay_end) begin
      b = crc_r[7:0];
    end else begin
      b = crc_r[15:8];
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      word_b[8*j +: 8] = (wc_r == 3'(j)) ? b : asm_r[8*j +: 8];
    end
  end

  assign crc1      = crc_step(crc_r, b);
  assign crc_upd   = (p_r == crc_p) ? crc_step(crc1, head.extra) : crc1;
  assign crc_hit   = (p_r != PW'(0)) && (p_r <= crc_p);
  assign is_final  = (p_r == last_p);
  assign completes = (wc_r == 3'd7) || is_final;
  assign advance   = (state_r == ST_RUN) && (!completes || out_free);

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    crc_nxt       = crc_r;
    wc_nxt        = wc_r;
    asm_nxt       = asm_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        p_nxt   = '0;
        crc_nxt = 16'hFFFF;
        wc_nxt  = '0;
        asm_nxt = '0;
        if (!q_stat.empty) begin
          if (head.too_long) begin
            if (out_free) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.frame_word = '0;
              out_data_nxt.byte_count = '0;
              out_data_nxt.frame_last = 1'b1;
              out_data_nxt.too_long   = 1'b1;
              pop                     = 1'b1;
            end
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (advance) begin
          p_nxt = p_r + PW'(1);
          if (crc_hit) begin
            crc_nxt = crc_upd;
          end
          if (completes) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.frame_word = word_b;
            out_data_nxt.byte_count = {1'b0, wc_r} + 4'd1;
            out_data_nxt.frame_last = is_final;
            out_data_nxt.too_long   = 1'b0;
            asm_nxt                 = '0;
            wc_nxt                  = '0;
          end else begin
            asm_nxt = word_b;
            wc_nxt  = wc_r + 3'd1;
          end
          if (is_final) begin
            pop       = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM read is issued in the cycle before the byte it feeds.
  assign rd_full     = p_nxt - PW'(mav2fb_pkg::HDR_LEN);
  assign ram_rd_addr = {q_stat.rd_slot, rd_full[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_r         <= '0;
      crc_r       <= 16'hFFFF;
      wc_r        <= '0;
      asm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      crc_r       <= crc_nxt;
      wc_r        <= wc_nxt;
      asm_r       <= asm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_run_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !q_stat.empty)
    else $error("frame walk without a queued message");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.too_long) |->
      (out_data_r.byte_count == 4'd0 && out_data_r.frame_last))
    else $error("error beat malformed");

  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.too_long) |->
      (out_data_r.byte_count != 4'd0 && out_data_r.byte_count <= 4'd8))
    else $error("frame word byte count out of range");

endmodule
